[rtl/pmra_pkg.sv]
// Shared types, constants and address helpers for the pedestal accumulator.
package pmra_pkg;

  // Geometry of the digitizer system.
  localparam int BOARDS   = 10;
  localparam int CHIPS    = 4;
  localparam int CHANNELS = 9;
  localparam int SAMPLES  = 256;

  localparam int NCELLS  = BOARDS * CHIPS * CHANNELS * SAMPLES;
  localparam int CHIP_N  = BOARDS * CHIPS;
  localparam int CELL_AW = (NCELLS > 1) ? $clog2(NCELLS) : 1;
  localparam int CHIP_AW = (CHIP_N > 1) ? $clog2(CHIP_N) : 1;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int BOARD_W = 4;
  localparam int CHIP_W  = 2;
  localparam int CHAN_W  = 4;
  localparam int SAMP_W  = 8;
  localparam int WORD_W  = 13;
  localparam int VAL_W   = 12;
  localparam int SUM_W   = 32;
  localparam int SQ_W    = 44;
  localparam int CNT_W   = 20;
  localparam int RMS_W   = 8;
  localparam int MINC_W  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration port.
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 12;
  localparam logic [CFG_IW-1:0] REG_VALUE_MASK = 2'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_COUNT  = 2'd1;
  localparam logic [VAL_W-1:0]  MASK_RESET     = 12'hFFF;
  localparam logic [MINC_W-1:0] MINC_RESET     = 8'd2;

  // Shared divider: on the RMS pass the numerator holds 400 times the variance term.
  localparam int DIV_NW = 73;
  localparam int DIV_DW = CNT_W + 1;
  localparam int DIV_CW = $clog2(DIV_NW + 1);
  localparam int LIM_W  = 53;

  typedef enum logic [OP_W-1:0] {
    OP_ACC  = 2'd0,
    OP_EVT  = 2'd1,
    OP_READ = 2'd2,
    OP_CLR  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [BOARD_W-1:0] board;
    logic [CHIP_W-1:0]  chip;
    logic [CHAN_W-1:0]  channel;
    logic [SAMP_W-1:0]  sample;
    logic [WORD_W-1:0]  word;
    logic               prev_hitbus;
    logic               next_hitbus;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic [SQ_W-1:0]  sum_sq;
    logic [SUM_W-1:0] sum;
  } cell_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
  } div_rsp_t;

  function automatic logic chip_ok(logic [BOARD_W-1:0] board, logic [CHIP_W-1:0] chip);
    return (32'(board) < BOARDS) && (32'(chip) < CHIPS);
  endfunction

  function automatic logic cell_ok(logic [BOARD_W-1:0] board, logic [CHIP_W-1:0] chip,
                                   logic [CHAN_W-1:0] channel, logic [SAMP_W-1:0] sample);
    return chip_ok(board, chip) && (32'(channel) < CHANNELS) && (32'(sample) < SAMPLES);
  endfunction

  function automatic logic [CHIP_AW-1:0] chip_idx(logic [BOARD_W-1:0] board,
                                                  logic [CHIP_W-1:0] chip);
    logic [31:0] idx;
    idx = 32'(board) * CHIPS + 32'(chip);
    return CHIP_AW'(idx);
  endfunction

  function automatic logic [CELL_AW-1:0] cell_addr(logic [BOARD_W-1:0] board,
                                                   logic [CHIP_W-1:0] chip,
                                                   logic [CHAN_W-1:0] channel,
                                                   logic [SAMP_W-1:0] sample);
    logic [31:0] idx;
    idx = ((32'(board) * CHIPS + 32'(chip)) * CHANNELS + 32'(channel)) * SAMPLES
          + 32'(sample);
    return CELL_AW'(idx);
  endfunction

endpackage

[rtl/pmra_if.sv]
// Channel interfaces: request, result and configuration write.
interface pmra_req_if;
  import pmra_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [BOARD_W-1:0]  board;
  logic [CHIP_W-1:0]   chip;
  logic [CHAN_W-1:0]   channel;
  logic [SAMP_W-1:0]   sample;
  logic [WORD_W-1:0]   word;
  logic                prev_hitbus;
  logic                next_hitbus;
  modport source (output valid, op, board, chip, channel, sample, word, prev_hitbus,
                  next_hitbus, input ready);
  modport sink (input valid, op, board, chip, channel, sample, word, prev_hitbus,
                next_hitbus, output ready);
endinterface

interface pmra_rsp_if;
  import pmra_pkg::*;
  logic              valid;
  logic              ready;
  logic [VAL_W-1:0]  ped_mean;
  logic [RMS_W-1:0]  rms_x10;
  logic [CNT_W-1:0]  cell_count;
  logic [CNT_W-1:0]  event_count;
  modport source (output valid, ped_mean, rms_x10, cell_count, event_count, input ready);
  modport sink (input valid, ped_mean, rms_x10, cell_count, event_count, output ready);
endinterface

interface pmra_cfg_if;
  import pmra_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/pmra_cell_mem.sv]
// Single-port cell statistics memory with a registered read.
module pmra_cell_mem (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pmra_pkg::CELL_AW-1:0]  addr_i,
  input  pmra_pkg::cell_t               wdata_i,
  output pmra_pkg::cell_t               rdata_o
);
  import pmra_pkg::*;

  cell_t mem_q [NCELLS];
  cell_t rdata_q;

  // Read-first port: the read returns the entry before this cycle's write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pmra_evt_cnt.sv]
// Event counter memory, one entry per board and chip, with a registered read.
module pmra_evt_cnt (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pmra_pkg::CHIP_AW-1:0]  addr_i,
  input  logic [pmra_pkg::CNT_W-1:0]    wdata_i,
  output logic [pmra_pkg::CNT_W-1:0]    rdata_o
);
  import pmra_pkg::*;

  logic [CNT_W-1:0] mem_q [CHIP_N];
  logic [CNT_W-1:0] rdata_q;

  // Read-first port: the read returns the entry before this cycle's write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pmra_div.sv]
// Restoring divider, one quotient bit per cycle.
module pmra_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pmra_pkg::div_req_t req_i,
  output pmra_pkg::div_rsp_t rsp_o
);
  import pmra_pkg::*;

  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q;
  logic [DIV_NW-1:0] num_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  // Shift the next numerator bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem_q, num_q[DIV_NW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CW'(DIV_NW);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - DIV_CW'(1);
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: the numerator register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q && (cnt_q != '0)) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      num_q <= {num_q[DIV_NW-2:0], ge};
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == '0);
  assign rsp_o.quot = num_q;

endmodule

[rtl/pedestal_mean_rms_accumulator.sv]
// Pedestal accumulator: per-cell sum, sum of squares and count, with mean and RMS readout.
//
// One request is handled at a time. After reset the block runs a clearing pass over all
// 92160 cell memory entries, one entry per cycle, before it takes its first request; the
// event counters are zeroed during the same pass, and configuration writes are taken
// during it. An event-count request and an accumulate go through a read state and a modify
// state, the read-modify-write of the single-port memories; a clear writes in the read
// state. A readout makes two passes through the bit-serial divider, for the mean and for
// the scaled variance, and a bit-by-bit search for the RMS; a readout of a cell with no
// spread ends after the variance test, and a readout below the minimum count or of an
// empty or invalid cell skips both. Results are held in an output register until taken;
// a readout waits in its output state while the previous result is still held.
module pedestal_mean_rms_accumulator (
  input logic         clk_i,
  input logic         rst_ni,
  pmra_req_if.sink    in_i,
  pmra_rsp_if.source  out_o,
  pmra_cfg_if.sink    cfg_i
);
  import pmra_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_MOD, S_MDIV, S_MUL, S_SUM, S_SUB,
    S_X1, S_X2, S_LDIV, S_SQA, S_SQB, S_OUT
  } state_e;

  state_e              state_q;
  req_t                req_q;
  logic                cell_ok_q;
  logic [CELL_AW-1:0]  addr_q;
  logic [CELL_AW-1:0]  clr_q;
  logic [VAL_W-1:0]    value_mask_q;
  logic [MINC_W-1:0]   min_count_q;
  logic [VAL_W-1:0]    v_q;
  logic [2*VAL_W-1:0]  vsq_q;
  logic [CNT_W-1:0]    n_q;
  logic [SUM_W-1:0]    s_q;
  logic [SQ_W-1:0]     sq_q;
  logic [VAL_W-1:0]    mean_q;
  logic [41:0]         plo_q;
  logic [41:0]         phi_q;
  logic [63:0]         ss_q;
  logic [63:0]         a_q;
  logic [63:0]         d_q;
  logic [DIV_NW-1:0]   x_q;
  logic [LIM_W-1:0]    lim_q;
  logic [RMS_W-1:0]    r_q;
  logic [2:0]          bit_q;
  logic [17:0]         ksq_q;
  logic                out_valid_q;
  logic [VAL_W-1:0]    out_mean_q;
  logic [RMS_W-1:0]    out_rms_q;
  logic [CNT_W-1:0]    out_cnt_q;
  logic [CNT_W-1:0]    out_evt_q;

  req_t                in_req;
  logic                in_acc;
  logic                skip;
  logic [VAL_W-1:0]    v_in;
  logic [RMS_W-1:0]    cand;
  logic [8:0]          k;
  logic [37:0]         kn;
  logic                mem_we;
  logic [CELL_AW-1:0]  mem_addr;
  cell_t               mem_wdata;
  cell_t               mem_rdata;
  logic                reportable;
  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic                evt_we;
  logic [CHIP_AW-1:0]  evt_addr;
  logic [CNT_W-1:0]    evt_wdata;
  logic [CNT_W-1:0]    evt_rdata;

  // Request capture.
  always_comb begin
    in_req.op          = op_e'(in_i.op);
    in_req.board       = in_i.board;
    in_req.chip        = in_i.chip;
    in_req.channel     = in_i.channel;
    in_req.sample      = in_i.sample;
    in_req.word        = in_i.word;
    in_req.prev_hitbus = in_i.prev_hitbus;
    in_req.next_hitbus = in_i.next_hitbus;
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Sample rejection and masked value.
  assign skip = req_q.word[WORD_W-1] || req_q.prev_hitbus || req_q.next_hitbus ||
                (req_q.word[VAL_W-1:0] == '0);
  assign v_in = req_q.word[VAL_W-1:0] & value_mask_q;

  // RMS search candidate and its odd multiplier 2r-1.
  assign cand = r_q | (RMS_W'(1) << bit_q);
  assign k    = {cand, 1'b0} - 9'd1;
  assign kn   = 38'(ksq_q * n_q);

  assign reportable = (mem_rdata.hits != '0) &&
                      (mem_rdata.hits >= {{(CNT_W-MINC_W){1'b0}}, min_count_q});

  // Cell memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      S_READ: begin
        mem_we = (req_q.op == OP_CLR) && cell_ok_q;
      end
      S_MOD: begin
        mem_we = (req_q.op == OP_ACC) && cell_ok_q && !skip && (mem_rdata.hits != CNT_MAX);
        mem_wdata.hits   = mem_rdata.hits + CNT_W'(1);
        mem_wdata.sum    = mem_rdata.sum + SUM_W'(v_q);
        mem_wdata.sum_sq = mem_rdata.sum_sq + SQ_W'(vsq_q);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Event counter port control: zeroed during the clearing pass, saturating increment.
  always_comb begin
    evt_we    = 1'b0;
    evt_addr  = chip_idx(req_q.board, req_q.chip);
    evt_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        evt_we   = (clr_q < CELL_AW'(CHIP_N));
        evt_addr = clr_q[CHIP_AW-1:0];
      end
      S_MOD: begin
        evt_we    = (req_q.op == OP_EVT) && chip_ok(req_q.board, req_q.chip) &&
                    (evt_rdata != CNT_MAX);
        evt_wdata = evt_rdata + CNT_W'(1);
      end
      default: begin
        evt_we = 1'b0;
      end
    endcase
  end

  // Divider requests: the mean on a readout, then the scaled variance.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_q)
      S_MOD: begin
        div_req.start = (req_q.op == OP_READ) && cell_ok_q && reportable;
        div_req.num   = DIV_NW'({mem_rdata.sum, 1'b0}) + DIV_NW'(mem_rdata.hits);
        div_req.den   = {mem_rdata.hits, 1'b0};
      end
      S_X2: begin
        div_req.start = 1'b1;
        div_req.num   = x_q + DIV_NW'({d_q, 4'b0});
        div_req.den   = {1'b0, n_q};
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  pmra_cell_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  pmra_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pmra_evt_cnt u_evt (
    .clk_i   (clk_i),
    .we_i    (evt_we),
    .addr_i  (evt_addr),
    .wdata_i (evt_wdata),
    .rdata_o (evt_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_mask_q <= MASK_RESET;
      min_count_q  <= MINC_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == REG_VALUE_MASK) begin
        value_mask_q <= cfg_i.data[VAL_W-1:0];
      end else if (cfg_i.index == REG_MIN_COUNT) begin
        min_count_q <= cfg_i.data[MINC_W-1:0];
      end
    end
  end

  // Sequencer: state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_OUT) && (!out_valid_q || out_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + CELL_AW'(1);
          if (clr_q == CELL_AW'(NCELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= (req_q.op == OP_CLR) ? S_IDLE : S_MOD;
        end
        S_MOD: begin
          if (req_q.op != OP_READ) begin
            state_q <= S_IDLE;
          end else if (cell_ok_q && reportable) begin
            state_q <= S_MDIV;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_MDIV: begin
          if (div_rsp.done) begin
            state_q <= S_MUL;
          end
        end
        S_MUL:  state_q <= S_SUM;
        S_SUM:  state_q <= S_SUB;
        S_SUB:  state_q <= (a_q <= ss_q) ? S_OUT : S_X1;
        S_X1:   state_q <= S_X2;
        S_X2:   state_q <= S_LDIV;
        S_LDIV: begin
          if (div_rsp.done) begin
            state_q <= S_SQA;
          end
        end
        S_SQA:  state_q <= S_SQB;
        S_SQB:  state_q <= (bit_q == 3'd0) ? S_OUT : S_SQA;
        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          req_q     <= in_req;
          cell_ok_q <= cell_ok(in_req.board, in_req.chip, in_req.channel, in_req.sample);
          addr_q    <= cell_addr(in_req.board, in_req.chip, in_req.channel, in_req.sample);
        end
      end
      S_READ: begin
        v_q   <= v_in;
        vsq_q <= v_in * v_in;
      end
      S_MOD: begin
        n_q    <= mem_rdata.hits;
        s_q    <= mem_rdata.sum;
        sq_q   <= mem_rdata.sum_sq;
        mean_q <= '0;
        r_q    <= '0;
      end
      S_MDIV: begin
        if (div_rsp.done) begin
          mean_q <= (|div_rsp.quot[DIV_NW-1:VAL_W]) ? '1 : div_rsp.quot[VAL_W-1:0];
        end
      end
      S_MUL: begin
        plo_q <= n_q * sq_q[21:0];
        phi_q <= n_q * sq_q[SQ_W-1:22];
        ss_q  <= s_q * s_q;
      end
      S_SUM: begin
        a_q <= {phi_q, 22'b0} + 64'(plo_q);
      end
      S_SUB: begin
        d_q <= a_q - ss_q;
      end
      S_X1: begin
        // 400 = 256 + 128 + 16; the last term is added at the divider's input.
        x_q <= DIV_NW'({d_q, 8'b0}) + DIV_NW'({d_q, 7'b0});
      end
      S_LDIV: begin
        if (div_rsp.done) begin
          lim_q <= div_rsp.quot[LIM_W-1:0];
          r_q   <= '0;
          bit_q <= 3'd7;
        end
      end
      S_SQA: begin
        ksq_q <= k * k;
      end
      S_SQB: begin
        if ({{(LIM_W-38){1'b0}}, kn} <= lim_q) begin
          r_q <= cand;
        end
        bit_q <= bit_q - 3'd1;
      end
      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_mean_q <= mean_q;
          out_rms_q  <= r_q;
          out_cnt_q  <= cell_ok_q ? n_q : '0;
          out_evt_q  <= cell_ok_q ? evt_rdata : '0;
        end
      end
      default: begin
        bit_q <= bit_q;
      end
    endcase
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ped_mean    = out_mean_q;
  assign out_o.rms_x10     = out_rms_q;
  assign out_o.cell_count  = out_cnt_q;
  assign out_o.event_count = out_evt_q;

endmodule

[tb/sv/pmra_checker.sv]
// Passive checker: tracks cell statistics, predicts readouts and compares them.
module pmra_checker (
  input logic  clk_i,
  pmra_req_if  req_ch,
  pmra_rsp_if  rsp_ch,
  pmra_cfg_if  cfg_ch,
  output int   fail_count_o,
  output int   pending_o,
  output int   reads_checked_o
);
  import pmra_pkg::*;

  typedef struct {
    logic [VAL_W-1:0] mean;
    logic [RMS_W-1:0] rms;
    logic [CNT_W-1:0] cells;
    logic [CNT_W-1:0] events;
  } readout_t;

  // Our own copy of the block's state; cells live in sparse stores keyed by address.
  logic [SUM_W-1:0] sum_store[int];
  logic [SQ_W-1:0]  sq_store[int];
  logic [CNT_W-1:0] hit_store[int];
  logic [CNT_W-1:0] event_store[CHIP_N];
  logic [VAL_W-1:0] mask_reg = MASK_RESET;
  logic [MINC_W-1:0] min_reg = MINC_RESET;
  readout_t readout_q[$];
  int fails = 0;
  int checked = 0;

  assign fail_count_o    = fails;
  assign pending_o       = readout_q.size();
  assign reads_checked_o = checked;

  initial begin
    foreach (event_store[i]) event_store[i] = '0;
  end

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("readout %0d: %s expected %0d, got %0d", checked, field, want, got);
    fails++;
  endtask

  // Ten times the RMS, rounded half up: largest r with (2r-1)^2 * n^2 <= 400 * D.
  function automatic logic [RMS_W-1:0] rms_x10_of(logic [CNT_W-1:0] n, logic [SUM_W-1:0] s,
                                                   logic [SQ_W-1:0] sq);
    logic [127:0] a, b, lim, k;
    int r;
    a = 128'(n) * 128'(sq);
    b = 128'(s) * 128'(s);
    if (a <= b) return '0;
    lim = (128'(400) * (a - b)) / 128'(n);
    r = 0;
    while (r < 255) begin
      k = 128'(2 * (r + 1) - 1);
      if (k * k * 128'(n) > lim) break;
      r++;
    end
    return RMS_W'(r);
  endfunction

  // Request side: update the state copy and queue the readouts that are due.
  always @(posedge clk_i) begin
    logic in_chip, in_cell;
    int key, ev;
    logic [VAL_W-1:0] v;
    logic [63:0] m;
    readout_t ro;
    if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_VALUE_MASK) mask_reg = cfg_ch.data[VAL_W-1:0];
      else if (cfg_ch.index == REG_MIN_COUNT) min_reg = cfg_ch.data[MINC_W-1:0];
    end
    if (req_ch.valid && req_ch.ready) begin
      in_chip = (int'(req_ch.board) < BOARDS) && (int'(req_ch.chip) < CHIPS);
      in_cell = in_chip && (int'(req_ch.channel) < CHANNELS)
                && (int'(req_ch.sample) < SAMPLES);
      ev  = int'(req_ch.board) * CHIPS + int'(req_ch.chip);
      key = (ev * CHANNELS + int'(req_ch.channel)) * SAMPLES + int'(req_ch.sample);
      if (in_cell && !hit_store.exists(key)) begin
        sum_store[key] = '0;
        sq_store[key]  = '0;
        hit_store[key] = '0;
      end
      case (op_e'(req_ch.op))
        OP_ACC: begin
          if (in_cell && !req_ch.word[VAL_W] && !req_ch.prev_hitbus && !req_ch.next_hitbus
              && req_ch.word[VAL_W-1:0] != '0 && hit_store[key] != CNT_MAX) begin
            v = req_ch.word[VAL_W-1:0] & mask_reg;
            sum_store[key] += SUM_W'(v);
            sq_store[key]  += SQ_W'(v) * SQ_W'(v);
            hit_store[key] += CNT_W'(1);
          end
        end
        OP_EVT: begin
          if (in_chip && event_store[ev] != CNT_MAX) event_store[ev] += CNT_W'(1);
        end
        OP_CLR: begin
          if (in_cell) begin
            sum_store[key] = '0;
            sq_store[key]  = '0;
            hit_store[key] = '0;
          end
        end
        default: begin
          ro = '{mean: '0, rms: '0, cells: '0, events: '0};
          if (in_cell) begin
            ro.cells  = hit_store[key];
            ro.events = event_store[ev];
            if (hit_store[key] != '0 && hit_store[key] >= CNT_W'(min_reg)) begin
              m = (64'(sum_store[key]) * 2 + 64'(hit_store[key]))
                  / (64'(hit_store[key]) * 2);
              ro.mean = (m > 64'hFFF) ? 12'hFFF : m[VAL_W-1:0];
              ro.rms  = rms_x10_of(hit_store[key], sum_store[key], sq_store[key]);
            end
          end
          readout_q.push_back(ro);
        end
      endcase
    end
  end

  // Result side: compare each readout with the oldest prediction.
  always @(posedge clk_i) begin
    readout_t ro;
    if (rsp_ch.valid && rsp_ch.ready) begin
      if (readout_q.size() == 0) begin
        $display("readout with no request outstanding");
        fails++;
      end else begin
        ro = readout_q.pop_front();
        if (rsp_ch.ped_mean !== ro.mean)
          report("ped_mean", 32'(ro.mean), 32'(rsp_ch.ped_mean));
        if (rsp_ch.rms_x10 !== ro.rms)
          report("rms_x10", 32'(ro.rms), 32'(rsp_ch.rms_x10));
        if (rsp_ch.cell_count !== ro.cells)
          report("cell_count", 32'(ro.cells), 32'(rsp_ch.cell_count));
        if (rsp_ch.event_count !== ro.events)
          report("event_count", 32'(ro.events), 32'(rsp_ch.event_count));
        checked++;
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the accumulator testbench: clock, reset, stimulus and verdict.
module testbench;
  import pmra_pkg::*;

  localparam int LIMIT  = 2_000_000;
  localparam int SETTLE = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int cycles = 0;
  int sent = 0;
  int fail_count, pending, reads_checked;
  logic gaps_on = 1'b1;

  pmra_req_if req_ch();
  pmra_rsp_if rsp_ch();
  pmra_cfg_if cfg_ch();

  pedestal_mean_rms_accumulator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_ch),
    .out_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  pmra_checker u_checker (
    .clk_i          (clk_i),
    .req_ch         (req_ch),
    .rsp_ch         (rsp_ch),
    .cfg_ch         (cfg_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .reads_checked_o(reads_checked)
  );

  always #1 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("pedestal_mean_rms_accumulator: mismatch");
      $finish;
    end
  end

  // Result receiver with random stalls.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = gaps_on ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send(req_t r);
    int gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.op          <= r.op;
    req_ch.board       <= r.board;
    req_ch.chip        <= r.chip;
    req_ch.channel     <= r.channel;
    req_ch.sample      <= r.sample;
    req_ch.word        <= r.word;
    req_ch.prev_hitbus <= r.prev_hitbus;
    req_ch.next_hitbus <= r.next_hitbus;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent++;
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  // Hold off until every readout is back and the block has finished its last request.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic req_t make_req(op_e op, int b, int c, int ch, int s, int w,
                                    int ph, int nh);
    req_t r;
    r.op = op;
    r.board = BOARD_W'(b);
    r.chip = CHIP_W'(c);
    r.channel = CHAN_W'(ch);
    r.sample = SAMP_W'(s);
    r.word = WORD_W'(w);
    r.prev_hitbus = ph[0];
    r.next_hitbus = nh[0];
    return r;
  endfunction

  // A small pool of cells so that reads find real statistics.
  int pool_b[6] = '{0, 9, 3, 5, 9, 1};
  int pool_c[6] = '{0, 3, 1, 2, 3, 0};
  int pool_ch[6] = '{0, 8, 4, 2, 8, 7};
  int pool_s[6] = '{0, 255, 17, 128, 254, 1};

  function automatic req_t pool_req(op_e op);
    int p;
    int w;
    p = $urandom_range(0, 5);
    w = $urandom_range(1, 4095);
    if ($urandom_range(0, 19) == 0) w = w | 32'h1000;
    if ($urandom_range(0, 29) == 0) w = 0;
    return make_req(op, pool_b[p], pool_c[p], pool_ch[p], pool_s[p], w,
                    int'($urandom_range(0, 24) == 0), int'($urandom_range(0, 24) == 0));
  endfunction

  task automatic random_items(int count);
    int pick;
    req_t r;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) gaps_on = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) r = pool_req(OP_ACC);
      else if (pick < 65) r = pool_req(OP_EVT);
      else if (pick < 85) r = pool_req(OP_READ);
      else if (pick < 89) r = pool_req(OP_CLR);
      else r = req_t'(35'({$urandom(), $urandom()}));
      send(r);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op = OP_ACC;
    req_ch.board = '0;
    req_ch.chip = '0;
    req_ch.channel = '0;
    req_ch.sample = '0;
    req_ch.word = '0;
    req_ch.prev_hitbus = 1'b0;
    req_ch.next_hitbus = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_VALUE_MASK;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with reset configuration.
    send(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_ACC, 0, 0, 0, 0, 'hFFF, 0, 0));
    send(make_req(OP_ACC, 0, 0, 0, 0, 1, 0, 0));
    send(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_ACC, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_ACC, 0, 0, 0, 0, 'h1FFF, 0, 0));
    send(make_req(OP_ACC, 0, 0, 0, 0, 'h800, 1, 0));
    send(make_req(OP_ACC, 0, 0, 0, 0, 'h800, 0, 1));
    send(make_req(OP_ACC, 0, 0, 0, 0, 'h555, 0, 0));
    send(make_req(OP_EVT, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_EVT, 15, 3, 0, 0, 0, 0, 0));
    send(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_ACC, 9, 3, 8, 255, 'hAAA, 0, 0));
    send(make_req(OP_ACC, 9, 3, 8, 255, 'hAAA, 0, 0));
    send(make_req(OP_READ, 9, 3, 8, 255, 0, 0, 0));
    send(make_req(OP_ACC, 10, 0, 0, 0, 5, 0, 0));
    send(make_req(OP_READ, 15, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_READ, 0, 0, 9, 0, 0, 0, 0));
    send(make_req(OP_READ, 0, 0, 15, 255, 0, 0, 0));
    send(make_req(OP_CLR, 0, 0, 15, 0, 0, 0, 0));
    send(make_req(OP_CLR, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    random_items(200);
    drain();

    // A mask of zero clears every value, and a minimum of zero reports every nonzero count.
    cfg_write(REG_VALUE_MASK, 12'h000);
    cfg_write(REG_MIN_COUNT, {4'hF, 8'd0});
    send(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    send(make_req(OP_ACC, 0, 0, 0, 0, 'h123, 0, 0));
    send(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    random_items(250);
    drain();

    // Random mask, minimum of one.
    cfg_write(REG_VALUE_MASK, 12'($urandom()));
    cfg_write(REG_MIN_COUNT, {4'($urandom()), 8'd1});
    random_items(250);
    drain();

    // Highest minimum: fill one cell past it.
    cfg_write(REG_VALUE_MASK, 12'hFFF);
    cfg_write(REG_MIN_COUNT, {4'h0, 8'd255});
    send(make_req(OP_CLR, 1, 0, 7, 1, 0, 0, 0));
    gaps_on = 1'b0;
    for (int i = 0; i < 260; i++) begin
      send(make_req(OP_ACC, 1, 0, 7, 1, $urandom_range(1, 4095), 0, 0));
      if (i == 253 || i == 254) send(make_req(OP_READ, 1, 0, 7, 1, 0, 0, 0));
    end
    gaps_on = 1'b1;
    send(make_req(OP_READ, 1, 0, 7, 1, 0, 0, 0));
    random_items(150);
    drain();

    // Random settings for the rest.
    cfg_write(REG_MIN_COUNT, 12'($urandom_range(0, 6)));
    cfg_write(REG_VALUE_MASK, 12'($urandom()));
    random_items(150);
    drain();

    $display("sent %0d requests over five register settings; %0d readouts checked",
             sent, reads_checked);
    if (fail_count == 0) begin
      $display("pedestal_mean_rms_accumulator: match");
    end else begin
      $display("pedestal_mean_rms_accumulator: mismatch");
    end
    $finish;
  end

endmodule
